// ===== sv/fpc_pkg.sv =====
package fpc_pkg;

	// widths of the ports and state
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned CAP_W    = 17;
	localparam int unsigned CRC_W    = 32;
	localparam int unsigned CFG_IDX_W = 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_ENABLE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 1'd1;

	// configuration reset values
	localparam logic             CRC_ENABLE_RST   = 1'b1;
	localparam logic [CAP_W-1:0] OUT_CAPACITY_RST = 17'd2100;

	// opcodes
	localparam logic OP_START   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	// frame constants
	localparam logic [CRC_W-1:0]  CRC_POLY       = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0]  CRC_INIT       = 32'hFFFF_FFFF;
	localparam logic [BYTE_W-1:0] SYNC_0         = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_1         = 8'h55;
	localparam logic [BYTE_W-1:0] TRAIL_0        = 8'hCC;
	localparam logic [BYTE_W-1:0] TRAIL_1        = 8'h33;
	localparam logic [CAP_W-1:0]  FRAME_OVERHEAD = 17'd11;

	// position of the emitter within the word sequence of one item
	typedef enum logic [3:0] {
		PH_START,
		PH_SYNC,
		PH_FLAG,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_DATA,
		PH_CRC0,
		PH_CRC1,
		PH_CRC2,
		PH_CRC3,
		PH_TRAIL0,
		PH_TRAIL1
	} phase_t;

	// reflected crc32 update over one byte, bit at a time
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== sv/frame_packer_crc32.sv =====
// frame_packer_crc32: turns start and payload words into a framed byte stream.
// Input channel (in_valid/in_stall): opcode 0 opens a frame with frame_flag and
// payload_length, opcode 1 carries one payload data_byte. Output channel
// (out_valid/out_stall): one out_byte per word, last_of_run marks the final
// byte caused by an input word, rejected marks a refused word (byte zero).
// A frame is AA 55 flag len_lo len_hi, payload, crc32 (lsb first), CC 33.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 crc_enable,
// index 1 out_capacity; write only while the block is idle.
// The first byte of an accepted word passes the input register, then the
// output register. The emitter produces one byte per cycle while the output
// is not stalled; an input word causes 1 byte for a mid-frame payload byte
// or a rejection, 5 for a start word, 7 for the last payload byte, 11 for an
// empty frame. The next word is taken in the cycle the previous one's last
// byte is emitted, so payload flows at one per cycle when not stalled.
// Reset closes the frame, sets the crc to CRC_INIT, loads config defaults.
// When out_stall is high with out_valid set, the output register holds, the
// emitter waits and in_stall rises once a word waits in the input register.
module frame_packer_crc32 (
	input  logic                         clk,
	input  logic                         arst_n,
	// input words
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [fpc_pkg::BYTE_W-1:0]   frame_flag,
	input  logic [fpc_pkg::LEN_W-1:0]    payload_length,
	input  logic [fpc_pkg::BYTE_W-1:0]   data_byte,
	// output words
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fpc_pkg::BYTE_W-1:0]   out_byte,
	output logic                         last_of_run,
	output logic                         rejected,
	// configuration writes
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpc_pkg::CAP_W-1:0]    cfg_data
);
	import fpc_pkg::*;

	// configuration
	logic             crc_en_q;
	logic [CAP_W-1:0] cap_q;

	// frame state
	logic [CRC_W-1:0] crc_q, crc_d;
	logic [LEN_W-1:0] rem_q, rem_d;
	logic             open_q, open_d;

	// input register
	logic              job_valid_s1;
	phase_t            phase_s1, phase_d;
	logic [BYTE_W-1:0] flag_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [BYTE_W-1:0] data_s1;

	// output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_rej_q;

	// emitter
	logic              adv;
	logic              step;
	logic              done;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_last;
	logic              emit_rej;
	logic [CRC_W-1:0]  crc_out;
	logic              in_acc;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_en_q <= CRC_ENABLE_RST;
			cap_q    <= OUT_CAPACITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CRC_ENABLE:   crc_en_q <= cfg_data[0];
				CFG_OUT_CAPACITY: cap_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// handshakes
	assign adv      = !out_valid_q || !out_stall;
	assign step     = job_valid_s1 && adv;
	assign in_stall = job_valid_s1 && !(adv && done);
	assign in_acc   = in_valid && !in_stall;

	assign crc_out = crc_en_q ? (crc_q ^ CRC_INIT) : '0;

	// next byte and state for the word in the input register
	always_comb begin
		crc_d     = crc_q;
		rem_d     = rem_q;
		open_d    = open_q;
		phase_d   = phase_s1;
		done      = 1'b0;
		emit_byte = '0;
		emit_last = 1'b0;
		emit_rej  = 1'b0;
		unique case (phase_s1)
			PH_START: begin
				open_d = 1'b0;
				rem_d  = '0;
				if ({1'b0, len_s1} + FRAME_OVERHEAD > cap_q) begin
					crc_d     = CRC_INIT;
					emit_last = 1'b1;
					emit_rej  = 1'b1;
					done      = 1'b1;
				end else begin
					emit_byte = SYNC_0;
					crc_d     = crc_byte(CRC_INIT, SYNC_0);
					phase_d   = PH_SYNC;
				end
			end
			PH_SYNC: begin
				emit_byte = SYNC_1;
				crc_d     = crc_byte(crc_q, SYNC_1);
				phase_d   = PH_FLAG;
			end
			PH_FLAG: begin
				emit_byte = flag_s1;
				crc_d     = crc_byte(crc_q, flag_s1);
				phase_d   = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				emit_byte = len_s1[7:0];
				crc_d     = crc_byte(crc_q, len_s1[7:0]);
				phase_d   = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				emit_byte = len_s1[15:8];
				crc_d     = crc_byte(crc_q, len_s1[15:8]);
				if (len_s1 == '0) begin
					phase_d = PH_CRC0;
				end else begin
					emit_last = 1'b1;
					done      = 1'b1;
					open_d    = 1'b1;
					rem_d     = len_s1;
				end
			end
			PH_DATA: begin
				if (!open_q || rem_q == '0) begin
					emit_last = 1'b1;
					emit_rej  = 1'b1;
					done      = 1'b1;
				end else begin
					emit_byte = data_s1;
					crc_d     = crc_byte(crc_q, data_s1);
					rem_d     = rem_q - 1'b1;
					if (rem_q == LEN_W'(1)) begin
						phase_d = PH_CRC0;
					end else begin
						emit_last = 1'b1;
						done      = 1'b1;
					end
				end
			end
			PH_CRC0: begin
				emit_byte = crc_out[7:0];
				phase_d   = PH_CRC1;
			end
			PH_CRC1: begin
				emit_byte = crc_out[15:8];
				phase_d   = PH_CRC2;
			end
			PH_CRC2: begin
				emit_byte = crc_out[23:16];
				phase_d   = PH_CRC3;
			end
			PH_CRC3: begin
				emit_byte = crc_out[31:24];
				phase_d   = PH_TRAIL0;
			end
			PH_TRAIL0: begin
				emit_byte = TRAIL_0;
				phase_d   = PH_TRAIL1;
			end
			PH_TRAIL1: begin
				emit_byte = TRAIL_1;
				emit_last = 1'b1;
				done      = 1'b1;
				open_d    = 1'b0;
				rem_d     = '0;
				crc_d     = CRC_INIT;
			end
			default: ;
		endcase
	end

	// input register and emitter position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			phase_s1     <= PH_START;
		end else if (in_acc) begin
			job_valid_s1 <= 1'b1;
			phase_s1     <= (opcode == OP_PAYLOAD) ? PH_DATA : PH_START;
		end else if (step && done) begin
			job_valid_s1 <= 1'b0;
		end else if (step) begin
			phase_s1 <= phase_d;
		end
	end

	// input payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			flag_s1 <= frame_flag;
			len_s1  <= payload_length;
			data_s1 <= data_byte;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			rem_q  <= '0;
			open_q <= 1'b0;
		end else if (step) begin
			crc_q  <= crc_d;
			rem_q  <= rem_d;
			open_q <= open_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
			out_rej_q  <= emit_rej;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;
	assign rejected    = out_rej_q;

	// checks
	a_acc_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> job_valid_s1)
		else $error("accepted word not held in input register");

	a_idle_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!job_valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

	a_rej_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> last_of_run && out_byte == '0)
		else $error("rejection word malformed");

	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> rem_q == '0)
		else $error("bytes remaining with no frame open");

	a_tail_crc_held: assert property (@(posedge clk) disable iff (!arst_n)
		step && (phase_s1 == PH_CRC0 || phase_s1 == PH_CRC1 || phase_s1 == PH_CRC2)
		|=> $stable(crc_q))
		else $error("crc changed while it is being sent");

endmodule
